// ===== hw/rtl/tsa_pkg.sv =====
// Package for the shared-array two-stack core.
// Holds the store geometry, the controller state type and the command and status structs.
// No dependencies.
package tsa_pkg;

	localparam int DEPTH     = 64;
	localparam int ELEM_BITS = 8;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int DATA_W    = 8;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;
	localparam logic SIDE_LEFT = 1'b0;
	localparam logic SIDE_RIGHT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_OUT
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load_item;   // latch the accepted item
		logic exec;        // check, update counts, touch the store, set the result
		logic load_rd;     // take the store's read data as the popped element
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic             pop_hit;   // the latched item is a pop that will succeed
		logic [CNT_W-1:0] left_cnt;
		logic [CNT_W-1:0] right_cnt;
	} status_t;

endpackage

// ===== hw/rtl/tsa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used for the shared element store.
module tsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/tsa_ctrl.sv =====
// Controller state machine of the shared-array two-stack core.
// Depends on tsa_pkg for the state type and the command and status structs.
module tsa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  tsa_pkg::status_t status,
	output tsa_pkg::cmd_t    cmd
);

	tsa_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			tsa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = tsa_pkg::ST_EXEC;
				end
			end
			tsa_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = status.pop_hit ? tsa_pkg::ST_READ : tsa_pkg::ST_OUT;
			end
			tsa_pkg::ST_READ: begin
				cmd.load_rd = 1'b1;
				state_d     = tsa_pkg::ST_OUT;
			end
			tsa_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = tsa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tsa_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/tsa_dp.sv =====
// Datapath of the shared-array two-stack core: item latch, stack counts, store and result.
// Depends on tsa_pkg and instantiates tsa_ram.
module tsa_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tsa_pkg::cmd_t                cmd,
	output tsa_pkg::status_t             status,
	input  logic                         func,
	input  logic                         side,
	input  logic [tsa_pkg::DATA_W-1:0]   data_in,
	output logic                         ok,
	output logic [tsa_pkg::DATA_W-1:0]   data_out
);

	logic                              func_q;
	logic                              side_q;
	logic [tsa_pkg::DATA_W-1:0]        data_q;
	logic [tsa_pkg::CNT_W-1:0]         left_cnt_q;
	logic [tsa_pkg::CNT_W-1:0]         right_cnt_q;
	logic                              ok_q;
	logic [tsa_pkg::DATA_W-1:0]        dout_q;

	logic [tsa_pkg::CNT_W:0]           used;
	logic                              full;
	logic                              empty;
	logic                              op_ok;
	logic [tsa_pkg::CNT_W-1:0]         left_m1;
	logic [tsa_pkg::CNT_W-1:0]         right_m1;
	logic [tsa_pkg::ADDR_W-1:0]        push_addr;
	logic [tsa_pkg::ADDR_W-1:0]        pop_addr;
	logic                              do_push;
	logic                              do_pop;
	logic [tsa_pkg::ELEM_BITS-1:0]     rd_data;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			func_q <= func;
			side_q <= side;
			data_q <= data_in;
		end
		if (cmd.exec) begin
			ok_q   <= op_ok;
			dout_q <= '0;
		end else if (cmd.load_rd) begin
			dout_q <= tsa_pkg::DATA_W'(rd_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_cnt_q  <= '0;
			right_cnt_q <= '0;
		end else begin
			if (do_push) begin
				if (side_q == tsa_pkg::SIDE_LEFT) begin
					left_cnt_q <= left_cnt_q + tsa_pkg::CNT_W'(1);
				end else begin
					right_cnt_q <= right_cnt_q + tsa_pkg::CNT_W'(1);
				end
			end else if (do_pop) begin
				if (side_q == tsa_pkg::SIDE_LEFT) begin
					left_cnt_q <= left_m1;
				end else begin
					right_cnt_q <= right_m1;
				end
			end
		end
	end

	always_comb begin
		used     = {1'b0, left_cnt_q} + {1'b0, right_cnt_q};
		full     = (used >= (tsa_pkg::CNT_W + 1)'(tsa_pkg::DEPTH));
		empty    = (side_q == tsa_pkg::SIDE_LEFT) ? (left_cnt_q == '0) : (right_cnt_q == '0);
		op_ok    = (func_q == tsa_pkg::FUNC_POP) ? !empty : !full;
		left_m1  = left_cnt_q - tsa_pkg::CNT_W'(1);
		right_m1 = right_cnt_q - tsa_pkg::CNT_W'(1);
		// Left grows up from entry 0, right grows down from the last entry.
		if (side_q == tsa_pkg::SIDE_LEFT) begin
			push_addr = left_cnt_q[tsa_pkg::ADDR_W-1:0];
			pop_addr  = left_m1[tsa_pkg::ADDR_W-1:0];
		end else begin
			push_addr = tsa_pkg::ADDR_W'(tsa_pkg::DEPTH - 1) - right_cnt_q[tsa_pkg::ADDR_W-1:0];
			pop_addr  = tsa_pkg::ADDR_W'(tsa_pkg::DEPTH - 1) - right_m1[tsa_pkg::ADDR_W-1:0];
		end
		do_push = cmd.exec && op_ok && (func_q == tsa_pkg::FUNC_PUSH);
		do_pop  = cmd.exec && op_ok && (func_q == tsa_pkg::FUNC_POP);
	end

	tsa_ram #(
		.WIDTH(tsa_pkg::ELEM_BITS),
		.DEPTH(tsa_pkg::DEPTH)
	) u_store (
		.clk  (clk),
		.we   (do_push),
		.waddr(push_addr),
		.wdata(tsa_pkg::ELEM_BITS'(data_q)),
		.re   (do_pop),
		.raddr(pop_addr),
		.rdata(rd_data)
	);

	assign status.pop_hit   = op_ok && (func_q == tsa_pkg::FUNC_POP);
	assign status.left_cnt  = left_cnt_q;
	assign status.right_cnt = right_cnt_q;
	assign ok               = ok_q;
	assign data_out         = dout_q;

endmodule

// ===== hw/rtl/shared_array_two_stack_core.sv =====
// Two stacks that share one store of 64 eight-bit entries. The left stack grows up from
// entry 0 and the right stack grows down from entry 63, so either may use all the room the
// other leaves free. Each input item asks for a push or a pop on one side and yields exactly
// one result item. A push fails (ok low) while the two stacks together fill the store; a pop
// fails while the chosen stack is empty. A successful pop returns the top element of that
// stack; every other result carries zero data. The core handles one item at a time: s_tready
// is high only while it is idle. A push or a failed operation steps the core through latch,
// execute and present: the item is latched as it is accepted, executed, and its result offered
// until m_tready takes it. A successful pop adds a read step between execute and present,
// because the store is a RAM with a registered read port, so the popped element is registered
// in the store before it is loaded as the result. Once the result is taken the core returns to
// idle and only then takes the next item. The counts reset to zero; the store itself is not
// cleared, and no entry is ever read before it is written.
module shared_array_two_stack_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// Input item.
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [tsa_pkg::DATA_W-1:0]  s_tdata,   // [7:0] data_in
	// [0] func (0 push, 1 pop), [1] side (0 left, 1 right)
	input  logic [1:0]                  s_tuser,
	// Result item.
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [tsa_pkg::DATA_W-1:0]  m_tdata,   // [7:0] data_out
	output logic [0:0]                  m_tuser    // [0] ok
);

	tsa_pkg::cmd_t    cmd;
	tsa_pkg::status_t status;
	logic             res_ok;

	// The controller sequences each item; the datapath owns the counts, the store and the result.
	tsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tsa_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.func    (s_tuser[0]),
		.side    (s_tuser[1]),
		.data_in (s_tdata),
		.ok      (res_ok),
		.data_out(m_tdata)
	);

	assign m_tuser[0] = res_ok;

	// The core never takes a new item while a result is still on offer.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input accepted while a result is pending");

	// An accepted item closes the input until its result has been delivered.
	a_closed_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input still open right after an accept");

	// The two stacks together never claim more entries than the store has.
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, status.left_cnt} + {1'b0, status.right_cnt}) <=
		(tsa_pkg::CNT_W + 1)'(tsa_pkg::DEPTH))
		else $error("stack counts exceed the store depth");

	// A failed operation reports zero data.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
		else $error("failed operation with nonzero data");

endmodule
